[rtl/tmds_palette_entry_encoder_assert.svh]
// Assertion macros for the TMDS palette entry encoder.
`ifndef TMDS_PALETTE_ENTRY_ENCODER_ASSERT_SVH
`define TMDS_PALETTE_ENTRY_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpe assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpe assertion failed (next cycle)");

`endif

[rtl/tpe_pkg.sv]
// Package: types, constants and helpers for the TMDS palette entry encoder.
`timescale 1ns / 1ps

package tpe_pkg;

  // First reserved control entry; indices at or above it are refused.
  localparam logic [8:0] CONTROL_BASE = 9'd251;

  // Mask of the low 50 bits applied to form the second word.
  localparam logic [61:0] LOW50_MASK = 62'h0003ffffffffffff;

  localparam int SYM_W      = 10;
  localparam int WORD_W     = 62;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indices.
  localparam logic [CFG_INDEX_W-1:0] CFG_RED_HIGH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT   = 2'd1;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic [23:0] color_rgb;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [7:0]        entry_number;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } out_item_t;

  // XNOR chaining when more than four ones, or exactly four with bit 0 clear.
  function automatic logic pick_xnor_chain(input logic [7:0] byte_in);
    logic [3:0] ones;
    ones = 4'd0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + {3'd0, byte_in[i]};
    end
    return (ones > 4'd4) || ((ones == 4'd4) && !byte_in[0]);
  endfunction

endpackage

[rtl/tpe_chan_encode.sv]
// Transition-minimized coding of one 8-bit channel into a 10-bit symbol.
`timescale 1ns / 1ps

module tpe_chan_encode (
  input  logic [7:0]               byte_in,
  input  logic                     xnor_sel,
  output logic [tpe_pkg::SYM_W-1:0] sym_out
);
  import tpe_pkg::*;

  logic [7:0] chain;

  // Bit chain: each bit combines the data bit with the previous coded bit.
  always_comb begin
    chain[0] = byte_in[0];
    for (int i = 1; i < 8; i++) begin
      chain[i] = chain[i-1] ^ byte_in[i] ^ xnor_sel;
    end
  end

  // Bit 9 flags XNOR, bit 8 flags XOR; no DC balancing.
  assign sym_out = {xnor_sel, ~xnor_sel, chain};

endmodule

[rtl/tmds_palette_entry_encoder.sv]
// Top level: three-stage pipelined TMDS palette entry encoder.
`timescale 1ns / 1ps

// Takes one palette write per cycle while in_stall is low and returns one
// result per write from the stage 3 output register. Stage 1 counts the
// ones of each channel and picks XOR or XNOR chaining, stage 2 builds the
// three 10-bit symbols, stage 3 serializes them into the 62-bit first word and
// forms the masked second word in the output register. Every stage has its
// own valid bit and fills a bubble even while a later stage is stalled, so a
// sustained rate of one item per cycle is limited only by the output side.
// Indices of 251 and above return accepted clear with both words zero.
// Configuration is sampled by stage 3 and must be written only while idle.
module tmds_palette_entry_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tpe_pkg::in_item_t                in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output tpe_pkg::out_item_t               out_data,
  // configuration port
  input  logic                             cfg_we,
  input  logic [tpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic                             cfg_wdata
);
  import tpe_pkg::*;

  // Configuration registers
  logic red_high_r, red_high_nxt;
  logic invert_r, invert_nxt;

  always_comb begin
    red_high_nxt = red_high_r;
    invert_nxt   = invert_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RED_HIGH: red_high_nxt = cfg_wdata;
        CFG_INVERT:   invert_nxt   = cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_high_r <= 1'b0;
      invert_r   <= 1'b0;
    end else begin
      red_high_r <= red_high_nxt;
      invert_r   <= invert_nxt;
    end
  end

  // Pipeline flow control: a stage loads when empty or when it moves on
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;

  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // Stage 1: range check and chaining choice per channel
  logic [7:0]  s1_idx_r;
  logic [23:0] s1_rgb_r;
  logic        s1_ok_r;
  logic [2:0]  s1_xnor_r;

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_idx_r  <= in_data.entry_index;
      s1_rgb_r  <= in_data.color_rgb;
      s1_ok_r   <= ({1'b0, in_data.entry_index} < CONTROL_BASE);
      s1_xnor_r <= {pick_xnor_chain(in_data.color_rgb[23:16]),
                    pick_xnor_chain(in_data.color_rgb[15:8]),
                    pick_xnor_chain(in_data.color_rgb[7:0])};
    end
  end

  // Stage 2: transition-minimized symbols
  logic [SYM_W-1:0] sym_r_c, sym_g_c, sym_b_c;
  logic [SYM_W-1:0] s2_sym_r_r, s2_sym_g_r, s2_sym_b_r;
  logic [7:0]       s2_idx_r;
  logic             s2_ok_r;

  tpe_chan_encode u_enc_red (
    .byte_in (s1_rgb_r[23:16]),
    .xnor_sel(s1_xnor_r[2]),
    .sym_out (sym_r_c)
  );

  tpe_chan_encode u_enc_green (
    .byte_in (s1_rgb_r[15:8]),
    .xnor_sel(s1_xnor_r[1]),
    .sym_out (sym_g_c)
  );

  tpe_chan_encode u_enc_blue (
    .byte_in (s1_rgb_r[7:0]),
    .xnor_sel(s1_xnor_r[0]),
    .sym_out (sym_b_c)
  );

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_sym_r_r <= sym_r_c;
      s2_sym_g_r <= sym_g_c;
      s2_sym_b_r <= sym_b_c;
      s2_idx_r   <= s1_idx_r;
      s2_ok_r    <= s1_ok_r;
    end
  end

  // Stage 3: MSB-first serialization into differential pairs
  logic [WORD_W-1:0] word_c;

  always_comb begin
    logic [1:0] rp, gp, bp;
    logic [5:0] grp;
    word_c = '0;
    for (int g = 0; g < SYM_W; g++) begin
      rp  = {~s2_sym_r_r[SYM_W-1-g], s2_sym_r_r[SYM_W-1-g]} ^ {2{invert_r}};
      gp  = {~s2_sym_g_r[SYM_W-1-g], s2_sym_g_r[SYM_W-1-g]} ^ {2{invert_r}};
      bp  = {~s2_sym_b_r[SYM_W-1-g], s2_sym_b_r[SYM_W-1-g]} ^ {2{invert_r}};
      grp = red_high_r ? {rp, gp, bp} : {bp, gp, rp};
      // upper five groups sit above the two-bit gap
      if (g < 5) begin
        word_c[6*(9-g)+2 +: 6] = grp;
      end else begin
        word_c[6*(9-g) +: 6] = grp;
      end
    end
  end

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (ready3) begin
      out_r.accepted     <= s2_ok_r;
      out_r.entry_number <= s2_idx_r;
      out_r.first_word   <= s2_ok_r ? word_c : '0;
      out_r.second_word  <= s2_ok_r ? (word_c ^ LOW50_MASK) : '0;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

  // Checks
`include "tmds_palette_entry_encoder_assert.svh"

  `TPE_ASSERT_NOW(a_refused_zero, clk, rst_n, out_valid && !out_data.accepted, (out_data.first_word == '0) && (out_data.second_word == '0))
  `TPE_ASSERT_NOW(a_second_mask, clk, rst_n, out_valid && out_data.accepted, out_data.second_word == (out_data.first_word ^ LOW50_MASK))
  `TPE_ASSERT_NOW(a_accept_range, clk, rst_n, out_valid, out_data.accepted == ({1'b0, out_data.entry_number} < CONTROL_BASE))
  `TPE_ASSERT_NEXT(a_stage2_hold, clk, rst_n, v2_r && !ready3, v2_r && $stable(s2_idx_r) && $stable(s2_sym_g_r))

endmodule

[tb/tmds_palette_entry_encoder_test.sv]
// Self-checking testbench for the TMDS palette entry encoder.
`timescale 1ns / 1ps

module tmds_palette_entry_encoder_test;
  import tpe_pkg::*;

  localparam int PIPE_LATENCY    = 3;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  // Index past the register list; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  // One row of the directed table. Reserved rows carry a typed expectation.
  typedef struct packed {
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic        reserved;
  } stim_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{8'd0,   24'h000000, 1'b0},   // all-zero channels, lowest index
    '{8'd250, 24'hffffff, 1'b0},   // all-ones channels, highest usable index
    '{8'd1,   24'h1e1e1e, 1'b0},   // four ones, bit 0 clear: XNOR chain
    '{8'd2,   24'h0f0f0f, 1'b0},   // four ones, bit 0 set: XOR chain
    '{8'd3,   24'h1f0703, 1'b0},   // five, three and two ones
    '{8'd4,   24'h80ff01, 1'b0},
    '{8'd5,   24'haa55aa, 1'b0},
    '{8'd6,   24'hf0e178, 1'b0},
    '{8'd127, 24'h123456, 1'b0},
    '{8'd128, 24'hfedcba, 1'b0},
    '{8'd170, 24'h00ff00, 1'b0},
    '{8'd85,  24'hff00ff, 1'b0},
    '{8'd249, 24'h7ffe80, 1'b0},
    '{8'd200, 24'he1f0c3, 1'b0},
    '{8'd10,  24'h010203, 1'b0},
    '{8'd11,  24'h8040c0, 1'b0},
    '{8'd251, 24'hffffff, 1'b1},   // first control entry
    '{8'd252, 24'h123456, 1'b1},
    '{8'd254, 24'h000000, 1'b1},
    '{8'd255, 24'ha5a5a5, 1'b1}    // top of the index range
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_RED_HIGH;
  logic cfg_wdata = 1'b0;

  // Shadow copies of the registers used for prediction.
  logic red_high_cfg = 1'b0;
  logic invert_cfg = 1'b0;

  // Traffic shaping controls.
  logic sender_gaps = 1'b1;
  logic receiver_gaps = 1'b1;
  logic hold_off_req = 1'b0;

  out_item_t palette_results_due[$];
  int entries_sent = 0;
  int reserved_sent = 0;
  int results_checked = 0;
  int fault_count = 0;
  int settings_used = 1;

  tmds_palette_entry_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transition-minimized 10-bit symbol of one channel byte.
  function automatic logic [9:0] tm_symbol(input logic [7:0] byte_in);
    logic [3:0] ones;
    logic chain_xnor;
    logic [9:0] sym;
    ones = 4'($countones(byte_in));
    chain_xnor = (ones > 4'd4) || ((ones == 4'd4) && !byte_in[0]);
    sym = '0;
    sym[0] = byte_in[0];
    for (int i = 1; i < 8; i++) begin
      sym[i] = sym[i-1] ^ byte_in[i] ^ chain_xnor;
    end
    sym[9] = chain_xnor;
    sym[8] = !chain_xnor;
    return sym;
  endfunction

  // Ten groups of three differential pairs, MSB of each symbol first.
  function automatic logic [WORD_W-1:0] pack_lane_word(input logic [9:0] r_sym,
                                                       input logic [9:0] g_sym,
                                                       input logic [9:0] b_sym,
                                                       input logic red_high,
                                                       input logic invert);
    logic [WORD_W-1:0] word;
    logic [1:0] r_pair;
    logic [1:0] g_pair;
    logic [1:0] b_pair;
    int base;
    word = '0;
    for (int k = 0; k < 10; k++) begin
      // pair is {not bit, bit}, optionally flipped
      r_pair = {~r_sym[9-k], r_sym[9-k]} ^ {2{invert}};
      g_pair = {~g_sym[9-k], g_sym[9-k]} ^ {2{invert}};
      b_pair = {~b_sym[9-k], b_sym[9-k]} ^ {2{invert}};
      // two-bit gap between the fifth and sixth groups
      base = (k < 5) ? 6 * (9 - k) + 2 : 6 * (9 - k);
      word[base +: 6] = red_high ? {r_pair, g_pair, b_pair} : {b_pair, g_pair, r_pair};
    end
    return word;
  endfunction

  function automatic out_item_t encode_palette_entry(input in_item_t item);
    out_item_t res;
    res = '0;
    res.entry_number = item.entry_index;
    if ({1'b0, item.entry_index} < CONTROL_BASE) begin
      res.accepted = 1'b1;
      res.first_word = pack_lane_word(tm_symbol(item.color_rgb[23:16]),
                                      tm_symbol(item.color_rgb[15:8]),
                                      tm_symbol(item.color_rgb[7:0]),
                                      red_high_cfg, invert_cfg);
      res.second_word = res.first_word ^ LOW50_MASK;
    end
    return res;
  endfunction

  // Bytes that sit on the XOR/XNOR decision boundary or at the extremes.
  function automatic logic [7:0] edge_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hff;
      2: b = 8'h0f;
      3: b = 8'hf0;
      4: b = 8'h1e;
      5: b = 8'he1;
      6: b = 8'h55;
      default: b = 8'haa;
    endcase
    return b;
  endfunction

  function automatic in_item_t random_entry();
    in_item_t item;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      item.entry_index = 8'($urandom_range(251, 255));
    end else if (pick < 4) begin
      item.entry_index = 8'($urandom_range(240, 250));
    end else begin
      item.entry_index = 8'($urandom_range(0, 250));
    end
    item.color_rgb = 24'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: item.color_rgb[23:16] = edge_byte();
        1: item.color_rgb[15:8] = edge_byte();
        default: item.color_rgb[7:0] = edge_byte();
      endcase
    end
    return item;
  endfunction

  // Offer one palette write; entered and left at a falling edge.
  task automatic push_entry(input in_item_t item, input logic typed,
                            input out_item_t typed_result);
    int gap;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    palette_results_due.push_back(typed ? typed_result : encode_palette_entry(item));
    entries_sent++;
    if ({1'b0, item.entry_index} >= CONTROL_BASE) reserved_sent++;
    @(negedge clk);
  endtask

  task automatic run_random_writes(input int count);
    for (int n = 0; n < count; n++) begin
      push_entry(random_entry(), 1'b0, '0);
    end
  endtask

  // Stop offering and wait until every result is back and the pipe is empty.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (palette_results_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    @(negedge clk);
  endtask

  // Back-to-back register writes keep cfg_we high; close with end_reg_writes.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      CFG_RED_HIGH: red_high_cfg = value;
      CFG_INVERT: invert_cfg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic end_reg_writes();
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  always begin : receiver
    int burst;
    @(negedge clk);
    if (hold_off_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      hold_off_req = 1'b0;
    end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 16);
      out_stall <= 1'b1;
      repeat (burst - 1) @(negedge clk);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (palette_results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("unexpected result: accepted=%0b entry=%0d first=%h second=%h",
                   out_data.accepted, out_data.entry_number,
                   out_data.first_word, out_data.second_word);
        end
      end else begin
        want = palette_results_due.pop_front();
        results_checked++;
        if (out_data.accepted !== want.accepted ||
            out_data.entry_number !== want.entry_number ||
            out_data.first_word !== want.first_word ||
            out_data.second_word !== want.second_word) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("mismatch on entry %0d (red_high=%0b invert=%0b)",
                     want.entry_number, red_high_cfg, invert_cfg);
            $display("  expected: accepted=%0b entry=%0d first=%h second=%h",
                     want.accepted, want.entry_number, want.first_word,
                     want.second_word);
            $display("  actual:   accepted=%0b entry=%0d first=%h second=%h",
                     out_data.accepted, out_data.entry_number,
                     out_data.first_word, out_data.second_word);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tmds_palette_entry_encoder verification failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t item;
    out_item_t refused;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table under the reset settings
    foreach (DIRECTED_ROWS[i]) begin
      item.entry_index = DIRECTED_ROWS[i].idx;
      item.color_rgb = DIRECTED_ROWS[i].rgb;
      refused = '0;
      refused.entry_number = DIRECTED_ROWS[i].idx;
      push_entry(item, DIRECTED_ROWS[i].reserved, refused);
    end
    drain_pipe();

    // Red in the high pair; the receiver holds off long enough to back up the pipe
    write_reg(CFG_RED_HIGH, 1'b1);
    end_reg_writes();
    hold_off_req = 1'b1;
    run_random_writes(150);
    drain_pipe();

    // Red high with inverted pairs
    write_reg(CFG_INVERT, 1'b1);
    end_reg_writes();
    run_random_writes(150);
    drain_pipe();

    // Blue high with inverted pairs; the spare index must be ignored
    write_reg(CFG_RED_HIGH, 1'b0);
    write_reg(CFG_SPARE, 1'b1);
    end_reg_writes();
    run_random_writes(150);
    drain_pipe();

    // Back to the reset settings at full rate, no idling on either side
    write_reg(CFG_INVERT, 1'b0);
    end_reg_writes();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    run_random_writes(180);
    drain_pipe();

    $display("%0d palette writes sent (%0d to reserved entries), %0d results compared",
             entries_sent, reserved_sent, results_checked);
    $display("covered %0d register phases of pair order and inversion, idle bursts and a full-pipe stall",
             settings_used);
    if (fault_count == 0 && palette_results_due.size() == 0) begin
      $display("tmds_palette_entry_encoder verification clean");
    end else begin
      $display("%0d failures, %0d results missing", fault_count, palette_results_due.size());
      $display("tmds_palette_entry_encoder verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tpe_pkg.sv
rtl/tpe_chan_encode.sv
rtl/tmds_palette_entry_encoder.sv
tb/tmds_palette_entry_encoder_test.sv
